[hw/rtl/ipv4lpt_pkg.sv]
// ---------------------------------------------------------------------------
// ipv4lpt_pkg
// Shared types, request and status codes and the mask helper for the IPv4
// longest prefix table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipv4lpt_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 6;
  localparam int ENTRY_W     = ADDR_W + LEN_W;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  localparam logic [1:0] REQ_ADD = 2'd0;
  localparam logic [1:0] REQ_DEL = 2'd1;

  typedef enum logic [3:0] {
    ST_ADDED    = 4'd0,
    ST_DUP      = 4'd1,
    ST_FULL     = 4'd2,
    ST_BADLEN   = 4'd3,
    ST_DELETED  = 4'd4,
    ST_NOTFOUND = 4'd5,
    ST_EMPTY    = 4'd6,
    ST_MATCH    = 4'd7,
    ST_NOMATCH  = 4'd8
  } status_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_len;
  } in_req_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] match_len;
  } out_res_t;

  // compare flags for one stored entry
  typedef struct packed {
    logic exact;
    logic covers;
  } match_t;

  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] sh;
    sh = MAX_LEN - len;
    if (len == '0) begin
      len_mask = '0;
    end else begin
      len_mask = {ADDR_W{1'b1}} << sh;
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ipv4lpt_ram.sv]
// ---------------------------------------------------------------------------
// ipv4lpt_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipv4lpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[hw/rtl/ipv4lpt_match.sv]
// ---------------------------------------------------------------------------
// ipv4lpt_match
// Compares one stored entry against the request: exact base and length,
// and whether the masked address equals the stored base.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipv4lpt_match
  import ipv4lpt_pkg::*;
(
  input  wire logic [ADDR_W-1:0] e_base,
  input  wire logic [LEN_W-1:0]  e_len,
  input  wire logic [ADDR_W-1:0] q_addr,
  input  wire logic [LEN_W-1:0]  q_len,
  output match_t                 flags
);

  always_comb begin
    flags.exact  = (e_base == q_addr) && (e_len == q_len);
    flags.covers = ((q_addr & len_mask(e_len)) == e_base);
  end

endmodule

`default_nettype wire

[hw/rtl/ipv4_longest_prefix_table.sv]
// ---------------------------------------------------------------------------
// ipv4_longest_prefix_table
// Table of IPv4 prefixes with add, delete and longest prefix lookup.
// ---------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------
//  in      | in  | in_valid / in_ready  | in_data  (req, address, len)
//  out     | out | out_valid / out_ready| out_data (status, match_len)
//
// Each request scans the stored entries through the entry RAM read port,
// one entry a cycle; a delete that hits then reads the last entry in
// MOVE_RD and writes it into the freed slot in MOVE_WR. Adds and deletes
// with a bad length and any request on an empty table skip the scan.
// Reset clears state, entry count and valid flags; the RAM needs no clearing.
// A new beat is taken while the previous result waits in the output
// register; a finished result stalls only if that register is still full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipv4_longest_prefix_table
  import ipv4lpt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire in_req_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_res_t     out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_DEC, S_MOVE_RD, S_MOVE_WR, S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  in_req_t          req_r, req_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             vld_r, vld_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             found_r, found_nxt;
  logic [LEN_W-1:0] best_r, best_nxt;
  out_res_t         pend_r, pend_nxt;
  out_res_t         res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_wa, ram_ra;
  logic [ENTRY_W-1:0] ram_wd, ram_rd;
  match_t             flags;

  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] last_idx;
  logic             is_lookup, bad_len, table_full;

  assign cnt_m1     = count_r - CNT_W'(1);
  assign last_idx   = cnt_m1[IDX_W-1:0];
  assign is_lookup  = (req_r.req_type != REQ_ADD) && (req_r.req_type != REQ_DEL);
  assign bad_len    = req_r.prefix_len > MAX_LEN;
  assign table_full = (count_r == CNT_W'(TABLE_DEPTH));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  ipv4lpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  ipv4lpt_match u_match (
    .e_base (ram_rd[ENTRY_W-1:LEN_W]),
    .e_len  (ram_rd[LEN_W-1:0]),
    .q_addr (req_r.address),
    .q_len  (req_r.prefix_len),
    .flags  (flags)
  );

  // writes happen only in DEC and MOVE_WR, never while a read is in flight
  always_comb begin
    ram_ra = (state_r == S_MOVE_RD) ? last_idx : rd_idx_r;
    ram_we = 1'b0;
    ram_wa = count_r[IDX_W-1:0];
    ram_wd = {req_r.address, req_r.prefix_len};
    if (state_r == S_DEC && req_r.req_type == REQ_ADD && !bad_len && !hit_r &&
        !table_full) begin
      ram_we = 1'b1;
    end
    if (state_r == S_MOVE_WR) begin
      ram_we = 1'b1;
      ram_wa = hit_idx_r;
      ram_wd = ram_rd;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    vld_nxt       = 1'b0;
    chk_idx_nxt   = rd_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    pend_nxt      = pend_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;

    // evaluate the entry read last cycle
    if (vld_r) begin
      if (flags.exact && !hit_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = chk_idx_r;
      end
      if (flags.covers && (!found_r || ram_rd[LEN_W-1:0] > best_r)) begin
        found_nxt = 1'b1;
        best_nxt  = ram_rd[LEN_W-1:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          rd_idx_nxt = '0;
          hit_nxt    = 1'b0;
          found_nxt  = 1'b0;
          best_nxt   = '0;
          if (count_r == '0 ||
              ((in_data.req_type == REQ_ADD || in_data.req_type == REQ_DEL) &&
               in_data.prefix_len > MAX_LEN)) begin
            state_nxt = S_DEC;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        vld_nxt     = 1'b1;
        chk_idx_nxt = rd_idx_r;
        if (rd_idx_r == last_idx) begin
          state_nxt = S_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_DEC;
      end
      S_DEC: begin
        pend_nxt.match_len = '0;
        state_nxt          = S_FIN;
        if (is_lookup) begin
          if (found_r) begin
            pend_nxt.status    = ST_MATCH;
            pend_nxt.match_len = best_r;
          end else begin
            pend_nxt.status = ST_NOMATCH;
          end
        end else if (bad_len) begin
          pend_nxt.status = ST_BADLEN;
        end else if (req_r.req_type == REQ_ADD) begin
          if (hit_r) begin
            pend_nxt.status = ST_DUP;
          end else if (table_full) begin
            pend_nxt.status = ST_FULL;
          end else begin
            pend_nxt.status = ST_ADDED;
            count_nxt       = count_r + CNT_W'(1);
          end
        end else if (count_r == '0) begin
          pend_nxt.status = ST_EMPTY;
        end else if (!hit_r) begin
          pend_nxt.status = ST_NOTFOUND;
        end else begin
          pend_nxt.status = ST_DELETED;
          state_nxt       = S_MOVE_RD;
        end
      end
      S_MOVE_RD: begin
        state_nxt = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        count_nxt = cnt_m1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          res_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r     <= req_nxt;
    rd_idx_r  <= rd_idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    hit_r     <= hit_nxt;
    hit_idx_r <= hit_idx_nxt;
    found_r   <= found_nxt;
    best_r    <= best_nxt;
    pend_r    <= pend_nxt;
    res_r     <= res_nxt;
  end

endmodule

`default_nettype wire
